// ===== design/pdat_pkg.sv =====
// Shared types, constants and saturation helpers for the PD attitude torque unit.
package pdat_pkg;

   localparam int DATA_W     = 16;
   localparam int ERR_W      = DATA_W + 1;
   localparam int PROD_W     = ERR_W + ERR_W;
   localparam int GPROD_W    = DATA_W + DATA_W;
   localparam int U_W        = PROD_W + 1;
   localparam int JCOEF_W    = 13;
   localparam int DJCOEF_W   = 12;
   localparam int GYRO_W     = DJCOEF_W + GPROD_W;
   localparam int JU_W       = JCOEF_W + U_W;
   localparam int SUM_W      = JU_W + 1;
   localparam int FRAC_SHIFT = 27;
   localparam int SHIFT_W    = SUM_W - FRAC_SHIFT;
   localparam int NUM_STAGES = 5;
   localparam int CSR_IDX_W  = 3;

   typedef logic signed [DATA_W-1:0]   sample_type;
   typedef logic        [DATA_W-1:0]   gain_type;
   typedef logic signed [ERR_W-1:0]    err_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [GPROD_W-1:0]  gprod_type;
   typedef logic signed [U_W-1:0]      u_type;
   typedef logic signed [JCOEF_W-1:0]  jcoef_type;
   typedef logic signed [DJCOEF_W-1:0] djcoef_type;
   typedef logic signed [GYRO_W-1:0]   gyro_type;
   typedef logic signed [JU_W-1:0]     ju_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic signed [SHIFT_W-1:0]  shift_type;
   typedef logic        [CSR_IDX_W-1:0] csr_idx_type;

   typedef struct packed {
      logic ld_s1;
      logic ld_s2;
      logic ld_s3;
      logic ld_s4;
      logic ld_s5;
   } stage_en_type;

   // inertias, Q0.16
   localparam jcoef_type J_XX = 13'sd2694;
   localparam jcoef_type J_YY = 13'sd3133;
   localparam jcoef_type J_ZZ = 13'sd3926;

   // gyroscopic inertia differences
   localparam djcoef_type DJ_ROLL  = 12'sd793;    // Jzz - Jyy
   localparam djcoef_type DJ_PITCH = -12'sd1232;  // Jxx - Jzz
   localparam djcoef_type DJ_YAW   = 12'sd439;    // Jyy - Jxx

   localparam sum_type ROUND_HALF = sum_type'(1) <<< (FRAC_SHIFT - 1);

   localparam csr_idx_type CSR_ROLL_KP  = 3'd0;
   localparam csr_idx_type CSR_ROLL_KD  = 3'd1;
   localparam csr_idx_type CSR_PITCH_KP = 3'd2;
   localparam csr_idx_type CSR_PITCH_KD = 3'd3;
   localparam csr_idx_type CSR_YAW_KP   = 3'd4;
   localparam csr_idx_type CSR_YAW_KD   = 3'd5;

   localparam gain_type RST_ROLL_KP  = 16'd6144;
   localparam gain_type RST_ROLL_KD  = 16'd6554;
   localparam gain_type RST_PITCH_KP = 16'd6144;
   localparam gain_type RST_PITCH_KD = 16'd4915;
   localparam gain_type RST_YAW_KP   = 16'd6963;
   localparam gain_type RST_YAW_KD   = 16'd7782;

   localparam sample_type SAMPLE_MAX = 16'sh7fff;
   localparam sample_type SAMPLE_MIN = -16'sh8000;

   function automatic sample_type sat_err(input err_type x);
      sample_type r;
      if (x[ERR_W-1] != x[ERR_W-2]) begin
         r = x[ERR_W-1] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

   function automatic sample_type sat_shift(input shift_type x);
      sample_type r;
      if (!x[SHIFT_W-1] && (x[SHIFT_W-2:DATA_W-1] != '0)) begin
         r = SAMPLE_MAX;
      end else if (x[SHIFT_W-1] && (x[SHIFT_W-2:DATA_W-1] != '1)) begin
         r = SAMPLE_MIN;
      end else begin
         r = x[DATA_W-1:0];
      end
      return r;
   endfunction

endpackage

// ===== design/pdat_req_if.sv =====
// Input channel: measured and desired angles and rates.
interface pdat_req_if;
   import pdat_pkg::*;

   logic       valid;
   logic       ready;
   sample_type roll_meas;
   sample_type pitch_meas;
   sample_type yaw_meas;
   sample_type roll_rate_meas;
   sample_type pitch_rate_meas;
   sample_type yaw_rate_meas;
   sample_type roll_target;
   sample_type pitch_target;
   sample_type yaw_target;
   sample_type roll_rate_target;
   sample_type pitch_rate_target;
   sample_type yaw_rate_target;

   modport source (
      output valid, roll_meas, pitch_meas, yaw_meas, roll_rate_meas, pitch_rate_meas,
             yaw_rate_meas, roll_target, pitch_target, yaw_target, roll_rate_target,
             pitch_rate_target, yaw_rate_target,
      input  ready
   );

   modport sink (
      input  valid, roll_meas, pitch_meas, yaw_meas, roll_rate_meas, pitch_rate_meas,
             yaw_rate_meas, roll_target, pitch_target, yaw_target, roll_rate_target,
             pitch_rate_target, yaw_rate_target,
      output ready
   );
endinterface

// ===== design/pdat_rsp_if.sv =====
// Result channel: torques and rate errors.
interface pdat_rsp_if;
   import pdat_pkg::*;

   logic       valid;
   logic       ready;
   sample_type roll_torque;
   sample_type pitch_torque;
   sample_type yaw_torque;
   sample_type roll_rate_error;
   sample_type pitch_rate_error;
   sample_type yaw_rate_error;

   modport source (
      output valid, roll_torque, pitch_torque, yaw_torque, roll_rate_error,
             pitch_rate_error, yaw_rate_error,
      input  ready
   );

   modport sink (
      input  valid, roll_torque, pitch_torque, yaw_torque, roll_rate_error,
             pitch_rate_error, yaw_rate_error,
      output ready
   );
endinterface

// ===== design/pdat_ctrl.sv =====
// Pipeline valid tracking and per-stage load enables with bubble collapse.
module pdat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   output logic                   out_valid,
   input  logic                   out_ready,
   output pdat_pkg::stage_en_type en
);
   import pdat_pkg::*;

   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic [NUM_STAGES-1:0] free;

   always_comb begin
      free[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || out_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end
      valid_in[0] = free[0] ? in_valid : valid_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign in_ready  = free[0] && !reset;
   assign out_valid = valid_ff[NUM_STAGES-1];
   assign en        = '{ld_s1: free[0], ld_s2: free[1], ld_s3: free[2],
                        ld_s4: free[3], ld_s5: free[4]};
endmodule

// ===== design/pdat_lane.sv =====
// One axis lane: errors, PD command, gyroscopic term, round and saturate.
module pdat_lane (
   input  logic                   clock,
   input  pdat_pkg::stage_en_type en,
   input  pdat_pkg::sample_type   meas,
   input  pdat_pkg::sample_type   target,
   input  pdat_pkg::sample_type   rate_meas,
   input  pdat_pkg::sample_type   rate_target,
   input  pdat_pkg::sample_type   rate_b,
   input  pdat_pkg::sample_type   rate_c,
   input  pdat_pkg::gain_type     kp,
   input  pdat_pkg::gain_type     kd,
   input  pdat_pkg::jcoef_type    j_coef,
   input  pdat_pkg::djcoef_type   dj_coef,
   output pdat_pkg::sample_type   torque,
   output pdat_pkg::sample_type   rate_error
);
   import pdat_pkg::*;

   err_type    e_ff, e_in, er_ff, er_in;
   sample_type rb_ff, rb_in, rc_ff, rc_in;
   prod_type   pe_ff, pe_in, de_ff, de_in;
   gprod_type  g_ff, g_in;
   sample_type er2_ff, er2_in;
   u_type      u_ff, u_in;
   gyro_type   gy3_ff, gy3_in;
   sample_type er3_ff, er3_in;
   ju_type     ju_ff, ju_in;
   gyro_type   gy4_ff, gy4_in;
   sample_type er4_ff, er4_in;
   sample_type tq_ff, tq_in, er5_ff, er5_in;
   sum_type    sum;

   always_comb begin
      // s1: exact errors
      e_in   = ERR_W'(meas) - ERR_W'(target);
      er_in  = ERR_W'(rate_meas) - ERR_W'(rate_target);
      rb_in  = rate_b;
      rc_in  = rate_c;
      // s2: gain products, rate product
      pe_in  = PROD_W'($signed({1'b0, kp})) * PROD_W'(e_ff);
      de_in  = PROD_W'($signed({1'b0, kd})) * PROD_W'(er_ff);
      g_in   = GPROD_W'(rb_ff) * GPROD_W'(rc_ff);
      er2_in = sat_err(er_ff);
      // s3: PD command, gyroscopic term
      u_in   = -(U_W'(pe_ff) + U_W'(de_ff));
      gy3_in = GYRO_W'(dj_coef) * GYRO_W'(g_ff);
      er3_in = er2_ff;
      // s4: inertia scaling
      ju_in  = JU_W'(j_coef) * JU_W'(u_ff);
      gy4_in = gy3_ff;
      er4_in = er3_ff;
      // s5: align, round half up, saturate
      sum    = (SUM_W'(gy4_ff) <<< 1) + SUM_W'(ju_ff) + ROUND_HALF;
      tq_in  = sat_shift(sum[SUM_W-1:FRAC_SHIFT]);
      er5_in = er4_ff;
   end

   always_ff @(posedge clock) begin
      if (en.ld_s1) begin
         e_ff  <= e_in;
         er_ff <= er_in;
         rb_ff <= rb_in;
         rc_ff <= rc_in;
      end
      if (en.ld_s2) begin
         pe_ff  <= pe_in;
         de_ff  <= de_in;
         g_ff   <= g_in;
         er2_ff <= er2_in;
      end
      if (en.ld_s3) begin
         u_ff   <= u_in;
         gy3_ff <= gy3_in;
         er3_ff <= er3_in;
      end
      if (en.ld_s4) begin
         ju_ff  <= ju_in;
         gy4_ff <= gy4_in;
         er4_ff <= er4_in;
      end
      if (en.ld_s5) begin
         tq_ff  <= tq_in;
         er5_ff <= er5_in;
      end
   end

   assign torque     = tq_ff;
   assign rate_error = er5_ff;
endmodule

// ===== design/pd_attitude_torque_control_unit.sv =====
// Top level: gain registers, pipeline control and three axis lanes merged into one result.
//
//   channel   dir   handshake          contents
//   req_bus   in    valid / ready      angles, rates, targets (Q5.11)
//   rsp_bus   out   valid / ready      torques (Q4.12), rate errors (Q5.11)
//   csr_*     in    write enable only  six 16-bit gains, index 0..5
//
// Five-stage pipeline (s1 to s5 registers); one item per cycle unless rsp_bus stalls.
// Stage depth is set by the gain multiply, the inertia multiply and the final add/round.
// Each stage has a valid bit, so bubbles close up while rsp_bus is stalled.
// Reset clears the stage valid bits and loads the default gains.
module pd_attitude_torque_control_unit (
   input  logic                  clock,
   input  logic                  reset,
   pdat_req_if.sink              req_bus,
   pdat_rsp_if.source            rsp_bus,
   input  logic                  csr_write_en,
   input  pdat_pkg::csr_idx_type csr_index,
   input  pdat_pkg::gain_type    csr_write_data
);
   import pdat_pkg::*;

   gain_type roll_kp_ff, roll_kp_in, roll_kd_ff, roll_kd_in;
   gain_type pitch_kp_ff, pitch_kp_in, pitch_kd_ff, pitch_kd_in;
   gain_type yaw_kp_ff, yaw_kp_in, yaw_kd_ff, yaw_kd_in;

   stage_en_type en;
   logic         in_ready;
   logic         out_valid;

   always_comb begin
      roll_kp_in  = roll_kp_ff;
      roll_kd_in  = roll_kd_ff;
      pitch_kp_in = pitch_kp_ff;
      pitch_kd_in = pitch_kd_ff;
      yaw_kp_in   = yaw_kp_ff;
      yaw_kd_in   = yaw_kd_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_ROLL_KP:  roll_kp_in  = csr_write_data;
            CSR_ROLL_KD:  roll_kd_in  = csr_write_data;
            CSR_PITCH_KP: pitch_kp_in = csr_write_data;
            CSR_PITCH_KD: pitch_kd_in = csr_write_data;
            CSR_YAW_KP:   yaw_kp_in   = csr_write_data;
            CSR_YAW_KD:   yaw_kd_in   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         roll_kp_ff  <= RST_ROLL_KP;
         roll_kd_ff  <= RST_ROLL_KD;
         pitch_kp_ff <= RST_PITCH_KP;
         pitch_kd_ff <= RST_PITCH_KD;
         yaw_kp_ff   <= RST_YAW_KP;
         yaw_kd_ff   <= RST_YAW_KD;
      end else begin
         roll_kp_ff  <= roll_kp_in;
         roll_kd_ff  <= roll_kd_in;
         pitch_kp_ff <= pitch_kp_in;
         pitch_kd_ff <= pitch_kd_in;
         yaw_kp_ff   <= yaw_kp_in;
         yaw_kd_ff   <= yaw_kd_in;
      end
   end

   pdat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_bus.valid),
      .in_ready  (in_ready),
      .out_valid (out_valid),
      .out_ready (rsp_bus.ready),
      .en        (en)
   );

   pdat_lane u_roll (
      .clock       (clock),
      .en          (en),
      .meas        (req_bus.roll_meas),
      .target      (req_bus.roll_target),
      .rate_meas   (req_bus.roll_rate_meas),
      .rate_target (req_bus.roll_rate_target),
      .rate_b      (req_bus.pitch_rate_meas),
      .rate_c      (req_bus.yaw_rate_meas),
      .kp          (roll_kp_ff),
      .kd          (roll_kd_ff),
      .j_coef      (J_XX),
      .dj_coef     (DJ_ROLL),
      .torque      (rsp_bus.roll_torque),
      .rate_error  (rsp_bus.roll_rate_error)
   );

   pdat_lane u_pitch (
      .clock       (clock),
      .en          (en),
      .meas        (req_bus.pitch_meas),
      .target      (req_bus.pitch_target),
      .rate_meas   (req_bus.pitch_rate_meas),
      .rate_target (req_bus.pitch_rate_target),
      .rate_b      (req_bus.roll_rate_meas),
      .rate_c      (req_bus.yaw_rate_meas),
      .kp          (pitch_kp_ff),
      .kd          (pitch_kd_ff),
      .j_coef      (J_YY),
      .dj_coef     (DJ_PITCH),
      .torque      (rsp_bus.pitch_torque),
      .rate_error  (rsp_bus.pitch_rate_error)
   );

   pdat_lane u_yaw (
      .clock       (clock),
      .en          (en),
      .meas        (req_bus.yaw_meas),
      .target      (req_bus.yaw_target),
      .rate_meas   (req_bus.yaw_rate_meas),
      .rate_target (req_bus.yaw_rate_target),
      .rate_b      (req_bus.roll_rate_meas),
      .rate_c      (req_bus.pitch_rate_meas),
      .kp          (yaw_kp_ff),
      .kd          (yaw_kd_ff),
      .j_coef      (J_ZZ),
      .dj_coef     (DJ_YAW),
      .torque      (rsp_bus.yaw_torque),
      .rate_error  (rsp_bus.yaw_rate_error)
   );

   assign req_bus.ready = in_ready;
   assign rsp_bus.valid = out_valid;
endmodule

// ===== design/pdat_checker.sv =====
// Port-level checks for the PD attitude torque unit, bound to the top level.
module pdat_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input pdat_pkg::sample_type req_roll_rate_meas,
   input pdat_pkg::sample_type req_roll_rate_target,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input pdat_pkg::sample_type rsp_roll_torque,
   input pdat_pkg::sample_type rsp_roll_rate_error
);
   import pdat_pkg::*;

   function automatic sample_type exp_rate_err(input sample_type a, input sample_type b);
      err_type d;
      d = ERR_W'(a) - ERR_W'(b);
      return sat_err(d);
   endfunction

   // item taken as far back as the pipeline is deep, with no reset and no output stall since
   sequence s_clean_path;
      $past(req_valid && req_ready && !reset, 5) &&
      $past(rsp_ready, 1) && $past(rsp_ready, 2) &&
      $past(rsp_ready, 3) && $past(rsp_ready, 4) &&
      !$past(reset, 1) && !$past(reset, 2) && !$past(reset, 3) && !$past(reset, 4);
   endsequence

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_torque))
      else $error("stalled item changed or dropped");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      s_clean_path |-> rsp_valid)
      else $error("item missing after pipeline latency");

   a_rate_err: assert property (@(posedge clock) disable iff (reset)
      s_clean_path |-> rsp_roll_rate_error ==
         exp_rate_err($past(req_roll_rate_meas, 5), $past(req_roll_rate_target, 5)))
      else $error("roll rate error mismatch");
endmodule

bind pd_attitude_torque_control_unit pdat_checker u_pdat_checker (
   .clock                (clock),
   .reset                (reset),
   .req_valid            (req_bus.valid),
   .req_ready            (req_bus.ready),
   .req_roll_rate_meas   (req_bus.roll_rate_meas),
   .req_roll_rate_target (req_bus.roll_rate_target),
   .rsp_valid            (rsp_bus.valid),
   .rsp_ready            (rsp_bus.ready),
   .rsp_roll_torque      (rsp_bus.roll_torque),
   .rsp_roll_rate_error  (rsp_bus.roll_rate_error)
);

// ===== tb/testbench.sv =====
// Self-checking testbench for the PD attitude torque unit: directed table, random items, gain phases.
`timescale 1ns / 100ps

module testbench;
   import pdat_pkg::*;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int SETTLE_CYCLES   = 12;
   localparam int NUM_PHASES      = 7;
   localparam int PHASE_ITEMS     = 200;
   localparam int STEADY_PHASE    = 3;
   localparam int IDLE_PCT        = 24;

   localparam longint INERTIA_XX = 2694;
   localparam longint INERTIA_YY = 3133;
   localparam longint INERTIA_ZZ = 3926;

   localparam csr_idx_type CSR_SPARE_LO = 3'd6;
   localparam csr_idx_type CSR_SPARE_HI = 3'd7;
   localparam csr_idx_type GAIN_REGS [6] = '{CSR_ROLL_KP, CSR_ROLL_KD, CSR_PITCH_KP,
                                             CSR_PITCH_KD, CSR_YAW_KP, CSR_YAW_KD};

   typedef enum int {GS_RESET, GS_MAX, GS_ZERO, GS_RANDOM} gain_set_type;

   typedef struct packed {
      sample_type roll_meas;
      sample_type pitch_meas;
      sample_type yaw_meas;
      sample_type roll_rate_meas;
      sample_type pitch_rate_meas;
      sample_type yaw_rate_meas;
      sample_type roll_target;
      sample_type pitch_target;
      sample_type yaw_target;
      sample_type roll_rate_target;
      sample_type pitch_rate_target;
      sample_type yaw_rate_target;
   } attitude_sample_type;

   typedef struct packed {
      sample_type roll_torque;
      sample_type pitch_torque;
      sample_type yaw_torque;
      sample_type roll_rate_error;
      sample_type pitch_rate_error;
      sample_type yaw_rate_error;
   } torque_cmd_type;

   typedef struct {
      gain_set_type        gains;
      attitude_sample_type sample;
      bit                  typed;
      torque_cmd_type      cmd;
   } table_row_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   csr_idx_type csr_index;
   gain_type    csr_write_data;

   pdat_req_if req_bus ();
   pdat_rsp_if rsp_bus ();

   pd_attitude_torque_control_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   gain_type            gain_regs [0:5];
   gain_type            next_gains [0:5];
   torque_cmd_type      predicted_cmds [$];
   table_row_type       stim_table [$];
   bit                  steady;
   bit                  cmd_typed;
   torque_cmd_type      cmd_typed_value;
   int                  error_count;
   int                  items_taken;
   int                  cmds_checked;
   int                  gain_settings;
   int                  idle_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint sx(sample_type v);
      return longint'(v);
   endfunction

   function automatic longint sat16(longint x);
      if (x > 32767) begin
         return 32767;
      end else if (x < -32768) begin
         return -32768;
      end
      return x;
   endfunction

   function automatic sample_type axis_torque(longint e, longint er, gain_type kp, gain_type kd,
                                              longint j, longint dj, sample_type rb,
                                              sample_type rc);
      longint u;
      longint acc;
      u = -(longint'(kp) * e) - (longint'(kd) * er);
      acc = dj * sx(rb) * sx(rc) * 2 + j * u + (longint'(1) <<< 26);
      return sample_type'(sat16(acc >>> 27));
   endfunction

   function automatic torque_cmd_type predict_cmd(attitude_sample_type s);
      torque_cmd_type c;
      longint      e_roll;
      longint      e_pitch;
      longint      e_yaw;
      longint      er_roll;
      longint      er_pitch;
      longint      er_yaw;
      e_roll   = sx(s.roll_meas) - sx(s.roll_target);
      e_pitch  = sx(s.pitch_meas) - sx(s.pitch_target);
      e_yaw    = sx(s.yaw_meas) - sx(s.yaw_target);
      er_roll  = sx(s.roll_rate_meas) - sx(s.roll_rate_target);
      er_pitch = sx(s.pitch_rate_meas) - sx(s.pitch_rate_target);
      er_yaw   = sx(s.yaw_rate_meas) - sx(s.yaw_rate_target);
      c.roll_torque  = axis_torque(e_roll, er_roll, gain_regs[CSR_ROLL_KP],
                                   gain_regs[CSR_ROLL_KD], INERTIA_XX,
                                   INERTIA_ZZ - INERTIA_YY, s.pitch_rate_meas, s.yaw_rate_meas);
      c.pitch_torque = axis_torque(e_pitch, er_pitch, gain_regs[CSR_PITCH_KP],
                                   gain_regs[CSR_PITCH_KD], INERTIA_YY,
                                   INERTIA_XX - INERTIA_ZZ, s.roll_rate_meas, s.yaw_rate_meas);
      c.yaw_torque   = axis_torque(e_yaw, er_yaw, gain_regs[CSR_YAW_KP],
                                   gain_regs[CSR_YAW_KD], INERTIA_ZZ,
                                   INERTIA_YY - INERTIA_XX, s.roll_rate_meas, s.pitch_rate_meas);
      c.roll_rate_error  = sample_type'(sat16(er_roll));
      c.pitch_rate_error = sample_type'(sat16(er_pitch));
      c.yaw_rate_error   = sample_type'(sat16(er_yaw));
      return c;
   endfunction

   task automatic report_mismatch(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, sample_type got, sample_type want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
      end
   endtask

   // item and result monitor
   always @(posedge clock) begin
      torque_cmd_type want;
      torque_cmd_type got;
      attitude_sample_type s;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            s.roll_meas         = req_bus.roll_meas;
            s.pitch_meas        = req_bus.pitch_meas;
            s.yaw_meas          = req_bus.yaw_meas;
            s.roll_rate_meas    = req_bus.roll_rate_meas;
            s.pitch_rate_meas   = req_bus.pitch_rate_meas;
            s.yaw_rate_meas     = req_bus.yaw_rate_meas;
            s.roll_target       = req_bus.roll_target;
            s.pitch_target      = req_bus.pitch_target;
            s.yaw_target        = req_bus.yaw_target;
            s.roll_rate_target  = req_bus.roll_rate_target;
            s.pitch_rate_target = req_bus.pitch_rate_target;
            s.yaw_rate_target   = req_bus.yaw_rate_target;
            predicted_cmds.push_back(cmd_typed ? cmd_typed_value : predict_cmd(s));
            items_taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.roll_torque      = rsp_bus.roll_torque;
            got.pitch_torque     = rsp_bus.pitch_torque;
            got.yaw_torque       = rsp_bus.yaw_torque;
            got.roll_rate_error  = rsp_bus.roll_rate_error;
            got.pitch_rate_error = rsp_bus.pitch_rate_error;
            got.yaw_rate_error   = rsp_bus.yaw_rate_error;
            if (predicted_cmds.size() == 0) begin
               report_mismatch("result with no item outstanding");
            end else begin
               want = predicted_cmds.pop_front();
               check_field("roll_torque", got.roll_torque, want.roll_torque);
               check_field("pitch_torque", got.pitch_torque, want.pitch_torque);
               check_field("yaw_torque", got.yaw_torque, want.yaw_torque);
               check_field("roll_rate_error", got.roll_rate_error, want.roll_rate_error);
               check_field("pitch_rate_error", got.pitch_rate_error, want.pitch_rate_error);
               check_field("yaw_rate_error", got.yaw_rate_error, want.yaw_rate_error);
               cmds_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_write_en || (req_bus.valid && req_bus.ready) ||
          (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (steady) begin
         rsp_bus.ready <= 1'b1;
      end else begin
         rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic send_item(attitude_sample_type s, bit typed, torque_cmd_type cmd);
      @(negedge clock);
      while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      cmd_typed       = typed;
      cmd_typed_value = cmd;
      req_bus.valid             <= 1'b1;
      req_bus.roll_meas         <= s.roll_meas;
      req_bus.pitch_meas        <= s.pitch_meas;
      req_bus.yaw_meas          <= s.yaw_meas;
      req_bus.roll_rate_meas    <= s.roll_rate_meas;
      req_bus.pitch_rate_meas   <= s.pitch_rate_meas;
      req_bus.yaw_rate_meas     <= s.yaw_rate_meas;
      req_bus.roll_target       <= s.roll_target;
      req_bus.pitch_target      <= s.pitch_target;
      req_bus.yaw_target        <= s.yaw_target;
      req_bus.roll_rate_target  <= s.roll_rate_target;
      req_bus.pitch_rate_target <= s.pitch_rate_target;
      req_bus.yaw_rate_target   <= s.yaw_rate_target;
      do begin
         @(posedge clock);
      end while (!req_bus.ready);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (predicted_cmds.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic csr_write(csr_idx_type idx, gain_type val);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      @(posedge clock);
      if (idx <= CSR_YAW_KD) begin
         gain_regs[idx] = val;
      end
   endtask

   function automatic gain_type rand_gain();
      case ($urandom_range(0, 3))
         0: return '0;
         1: return '1;
         2: return gain_type'($urandom_range(0, 16383));
         default: return gain_type'($urandom);
      endcase
   endfunction

   task automatic load_gains(gain_set_type gs, bit spare_writes);
      for (int i = 0; i < 6; i++) begin
         case (gs)
            GS_MAX:  next_gains[i] = '1;
            GS_ZERO: next_gains[i] = '0;
            GS_RANDOM: next_gains[i] = rand_gain();
            default: next_gains[i] = '0;
         endcase
      end
      if (gs == GS_RESET) begin
         next_gains[CSR_ROLL_KP]  = RST_ROLL_KP;
         next_gains[CSR_ROLL_KD]  = RST_ROLL_KD;
         next_gains[CSR_PITCH_KP] = RST_PITCH_KP;
         next_gains[CSR_PITCH_KD] = RST_PITCH_KD;
         next_gains[CSR_YAW_KP]   = RST_YAW_KP;
         next_gains[CSR_YAW_KD]   = RST_YAW_KD;
      end
      for (int i = 0; i < 6; i++) begin
         csr_write(GAIN_REGS[i], next_gains[i]);
      end
      // writes past the last gain must leave every gain alone
      if (spare_writes) begin
         csr_write(CSR_SPARE_LO, gain_type'($urandom) | 16'h8001);
         csr_write(CSR_SPARE_HI, '1);
      end
      @(negedge clock);
      csr_write_en <= 1'b0;
      gain_settings++;
   endtask

   function automatic attitude_sample_type split(sample_type meas_v, sample_type targ_v);
      attitude_sample_type s;
      s.roll_meas = meas_v;    s.pitch_meas = meas_v;    s.yaw_meas = meas_v;
      s.roll_rate_meas = meas_v; s.pitch_rate_meas = meas_v; s.yaw_rate_meas = meas_v;
      s.roll_target = targ_v;  s.pitch_target = targ_v;  s.yaw_target = targ_v;
      s.roll_rate_target = targ_v; s.pitch_rate_target = targ_v; s.yaw_rate_target = targ_v;
      return s;
   endfunction

   task automatic add_row(gain_set_type gs, attitude_sample_type s, bit typed,
                          torque_cmd_type cmd);
      table_row_type r;
      r.gains  = gs;
      r.sample = s;
      r.typed  = typed;
      r.cmd    = cmd;
      stim_table.push_back(r);
   endtask

   function automatic sample_type rand_field();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
         return sample_type'(int'($urandom_range(0, 4096)) - 2048);
      end else if (pick < 8) begin
         return sample_type'($urandom);
      end
      case ($urandom_range(0, 4))
         0: return SAMPLE_MAX;
         1: return SAMPLE_MIN;
         2: return '0;
         3: return '1;
         default: return sample_type'(1);
      endcase
   endfunction

   function automatic sample_type near(sample_type v);
      return sample_type'(sx(v) + longint'($urandom_range(0, 512)) - 256);
   endfunction

   function automatic attitude_sample_type rand_sample();
      attitude_sample_type s;
      s.roll_meas       = rand_field();
      s.pitch_meas      = rand_field();
      s.yaw_meas        = rand_field();
      s.roll_rate_meas  = rand_field();
      s.pitch_rate_meas = rand_field();
      s.yaw_rate_meas   = rand_field();
      if ($urandom_range(0, 1)) begin
         // tracking close to the setpoint
         s.roll_target       = near(s.roll_meas);
         s.pitch_target      = near(s.pitch_meas);
         s.yaw_target        = near(s.yaw_meas);
         s.roll_rate_target  = near(s.roll_rate_meas);
         s.pitch_rate_target = near(s.pitch_rate_meas);
         s.yaw_rate_target   = near(s.yaw_rate_meas);
      end else begin
         s.roll_target       = rand_field();
         s.pitch_target      = rand_field();
         s.yaw_target        = rand_field();
         s.roll_rate_target  = rand_field();
         s.pitch_rate_target = rand_field();
         s.yaw_rate_target   = rand_field();
      end
      return s;
   endfunction

   initial begin
      attitude_sample_type s;
      torque_cmd_type      c;
      torque_cmd_type      none;
      gain_set_type        cur_gs;
      gain_set_type        phase_gs;

      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = CSR_ROLL_KP;
      csr_write_data = '0;
      req_bus.valid  = 1'b0;
      rsp_bus.ready  = 1'b0;
      req_bus.roll_meas = '0;        req_bus.pitch_meas = '0;        req_bus.yaw_meas = '0;
      req_bus.roll_rate_meas = '0;   req_bus.pitch_rate_meas = '0;   req_bus.yaw_rate_meas = '0;
      req_bus.roll_target = '0;      req_bus.pitch_target = '0;      req_bus.yaw_target = '0;
      req_bus.roll_rate_target = '0; req_bus.pitch_rate_target = '0; req_bus.yaw_rate_target = '0;
      steady          = 1'b0;
      cmd_typed       = 1'b0;
      cmd_typed_value = '0;
      error_count     = 0;
      items_taken     = 0;
      cmds_checked    = 0;
      gain_settings   = 0;
      idle_cycles     = 0;
      none            = '0;
      gain_regs[CSR_ROLL_KP]  = RST_ROLL_KP;
      gain_regs[CSR_ROLL_KD]  = RST_ROLL_KD;
      gain_regs[CSR_PITCH_KP] = RST_PITCH_KP;
      gain_regs[CSR_PITCH_KD] = RST_PITCH_KD;
      gain_regs[CSR_YAW_KP]   = RST_YAW_KP;
      gain_regs[CSR_YAW_KD]   = RST_YAW_KD;

      // directed table: reset gains first
      add_row(GS_RESET, split('0, '0), 1'b1, none);
      add_row(GS_RESET, split(SAMPLE_MAX, SAMPLE_MAX), 1'b0, none);
      add_row(GS_RESET, split(SAMPLE_MIN, SAMPLE_MIN), 1'b0, none);
      add_row(GS_RESET, split(SAMPLE_MAX, SAMPLE_MIN), 1'b0, none);
      add_row(GS_RESET, split(SAMPLE_MIN, SAMPLE_MAX), 1'b0, none);
      s = split('0, '0);
      s.roll_rate_meas = SAMPLE_MAX; s.pitch_rate_meas = SAMPLE_MAX; s.yaw_rate_meas = SAMPLE_MAX;
      add_row(GS_RESET, s, 1'b0, none);
      s = split('0, '0);
      s.roll_rate_meas = SAMPLE_MIN; s.pitch_rate_meas = SAMPLE_MAX; s.yaw_rate_meas = SAMPLE_MIN;
      s.roll_rate_target = SAMPLE_MIN; s.pitch_rate_target = SAMPLE_MAX;
      s.yaw_rate_target = SAMPLE_MIN;
      add_row(GS_RESET, s, 1'b0, none);
      s = split('0, '0);
      s.roll_meas = sample_type'(1); s.pitch_target = sample_type'(1);
      s.yaw_rate_meas = sample_type'(1);
      add_row(GS_RESET, s, 1'b0, none);

      // all gains at full scale: angle errors at the extremes saturate
      s = split('0, '0);
      s.roll_meas = SAMPLE_MAX;  s.roll_target = SAMPLE_MIN;
      s.pitch_meas = SAMPLE_MIN; s.pitch_target = SAMPLE_MAX;
      s.yaw_meas = 16'sd12345;   s.yaw_target = 16'sd12345;
      c = '0;
      c.roll_torque = SAMPLE_MIN;
      c.pitch_torque = SAMPLE_MAX;
      add_row(GS_MAX, s, 1'b1, c);
      add_row(GS_MAX, split('0, '0), 1'b1, none);
      add_row(GS_MAX, split(SAMPLE_MAX, SAMPLE_MIN), 1'b0, none);
      add_row(GS_MAX, split(16'sh5555, -16'sh5556), 1'b0, none);

      // zero gains: torque is the gyroscopic term only
      add_row(GS_ZERO, split('0, '0), 1'b1, none);
      s = split(SAMPLE_MAX, SAMPLE_MIN);
      s.roll_rate_meas = '0; s.pitch_rate_meas = '0; s.yaw_rate_meas = '0;
      s.roll_rate_target = SAMPLE_MIN; s.pitch_rate_target = SAMPLE_MAX;
      s.yaw_rate_target = sample_type'(1);
      c = '0;
      c.roll_rate_error = SAMPLE_MAX;
      c.pitch_rate_error = -16'sd32767;
      c.yaw_rate_error = '1;
      add_row(GS_ZERO, s, 1'b1, c);
      s = split('0, '0);
      s.roll_rate_meas = SAMPLE_MIN; s.roll_rate_target = sample_type'(1);
      c = '0;
      c.roll_rate_error = SAMPLE_MIN;
      add_row(GS_ZERO, s, 1'b1, c);
      add_row(GS_ZERO, split(SAMPLE_MAX, '0), 1'b0, none);

      add_row(GS_RESET, split(-16'sh5556, 16'sh5555), 1'b0, none);
      add_row(GS_RESET, split('0, '0), 1'b1, none);

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      cur_gs = GS_RESET;
      foreach (stim_table[i]) begin
         if (stim_table[i].gains != cur_gs) begin
            drain_results();
            load_gains(stim_table[i].gains, stim_table[i].gains == GS_ZERO);
            cur_gs = stim_table[i].gains;
         end
         send_item(stim_table[i].sample, stim_table[i].typed, stim_table[i].cmd);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         drain_results();
         case (p)
            0: phase_gs = GS_RESET;
            1: phase_gs = GS_MAX;
            2: phase_gs = GS_ZERO;
            default: phase_gs = GS_RANDOM;
         endcase
         if (p != 0) begin
            load_gains(phase_gs, $urandom_range(0, 1) == 1);
         end
         steady = (p == STEADY_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_item(rand_sample(), 1'b0, none);
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (predicted_cmds.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", predicted_cmds.size()));
      end
      $display("Ran %0d items (%0d from the directed table), checked %0d results,",
               items_taken, stim_table.size(), cmds_checked);
      $display("across %0d programmed gain settings plus the reset gains.", gain_settings);
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
